>>> sv/dtoi_pkg.sv
// Shared types and constants of the decimal text to 64-bit integer converter.
package dtoi_pkg;

    // Width of the converted number.
    localparam int unsigned NUM_W = 64;

    // Character codes the parser recognizes.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    // Parser phase within one span.
    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_SIGN  = 3'd1,
        PH_DIGIT = 3'd2,
        PH_TRAIL = 3'd3,
        PH_FAIL  = 3'd4
    } t_phase;

    // One input item.
    typedef struct packed {
        logic [7:0] char_code;
        logic       has_char;
        logic       span_end;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic             ok;
        logic             minus;
        logic [NUM_W-1:0] number;
    } t_out_item;

    // Finished span handed from the parser to the output stage.
    typedef struct packed {
        logic             well_formed;
        logic             neg;
        logic [NUM_W-1:0] mag;
    } t_fin;

endpackage

>>> sv/dtoi_parse.sv
// Character parser: phase tracking, decimal accumulation and span capture.
module dtoi_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  dtoi_pkg::t_in_item i_item,
    input  logic               i_out_free,
    output logic               o_fin_vld,
    output dtoi_pkg::t_fin     o_fin
);

    dtoi_pkg::t_phase               r_phase;
    dtoi_pkg::t_phase               n_phase;
    logic [dtoi_pkg::NUM_W-1:0]     r_accum;
    logic [dtoi_pkg::NUM_W-1:0]     n_accum;
    logic                           r_neg;
    logic                           n_neg;
    logic                           r_fin_vld;
    dtoi_pkg::t_fin                 r_fin;

    logic                           is_digit;
    logic                           is_blank;
    logic [dtoi_pkg::NUM_W+3:0]     prod;
    logic                           ovf;
    dtoi_pkg::t_phase               digit_phase;
    logic [dtoi_pkg::NUM_W-1:0]     digit_accum;
    logic                           fin_take;

    // Character classes.
    assign is_digit = (i_item.char_code >= dtoi_pkg::CH_ZERO)
                   && (i_item.char_code <= dtoi_pkg::CH_NINE);
    assign is_blank = (i_item.char_code == dtoi_pkg::CH_SPACE)
                   || (i_item.char_code == dtoi_pkg::CH_TAB);

    // Magnitude times ten plus the digit, as 8a + 2a + d with four guard bits.
    assign prod = {1'b0, r_accum, 3'b000}
                + {3'b000, r_accum, 1'b0}
                + {{(dtoi_pkg::NUM_W){1'b0}}, i_item.char_code[3:0]};
    assign ovf  = |prod[dtoi_pkg::NUM_W+3:dtoi_pkg::NUM_W];

    // Outcome of taking a digit: any overflow fails the whole span.
    always_comb begin
        if (ovf) begin
            digit_phase = dtoi_pkg::PH_FAIL;
            digit_accum = r_accum;
        end else begin
            digit_phase = dtoi_pkg::PH_DIGIT;
            digit_accum = prod[dtoi_pkg::NUM_W-1:0];
        end
    end

    // State after the character of this item is taken.
    always_comb begin
        n_phase = r_phase;
        n_accum = r_accum;
        n_neg   = r_neg;
        if (i_item.has_char) begin
            case (r_phase)
                dtoi_pkg::PH_LEAD: begin
                    if (is_blank) begin
                        n_phase = dtoi_pkg::PH_LEAD;
                    end else if (i_item.char_code == dtoi_pkg::CH_MINUS) begin
                        n_neg   = 1'b1;
                        n_phase = dtoi_pkg::PH_SIGN;
                    end else if (i_item.char_code == dtoi_pkg::CH_PLUS) begin
                        n_phase = dtoi_pkg::PH_SIGN;
                    end else if (is_digit) begin
                        n_phase = digit_phase;
                        n_accum = digit_accum;
                    end else begin
                        n_phase = dtoi_pkg::PH_FAIL;
                    end
                end
                dtoi_pkg::PH_SIGN: begin
                    if (is_digit) begin
                        n_phase = digit_phase;
                        n_accum = digit_accum;
                    end else begin
                        n_phase = dtoi_pkg::PH_FAIL;
                    end
                end
                dtoi_pkg::PH_DIGIT: begin
                    if (is_digit) begin
                        n_phase = digit_phase;
                        n_accum = digit_accum;
                    end else if (is_blank) begin
                        n_phase = dtoi_pkg::PH_TRAIL;
                    end else begin
                        n_phase = dtoi_pkg::PH_FAIL;
                    end
                end
                dtoi_pkg::PH_TRAIL: begin
                    if (!is_blank) begin
                        n_phase = dtoi_pkg::PH_FAIL;
                    end
                end
                default: begin
                    n_phase = dtoi_pkg::PH_FAIL;
                end
            endcase
        end
    end

    // Parser state; the last item of a span returns it to the start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dtoi_pkg::PH_LEAD;
            r_accum <= '0;
            r_neg   <= 1'b0;
        end else if (i_go) begin
            if (i_item.span_end) begin
                r_phase <= dtoi_pkg::PH_LEAD;
                r_accum <= '0;
                r_neg   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_accum <= n_accum;
                r_neg   <= n_neg;
            end
        end
    end

    assign fin_take = r_fin_vld && i_out_free;

    // Finished span waits here until the output stage takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_vld <= 1'b0;
        end else if (i_go && i_item.span_end) begin
            r_fin_vld <= 1'b1;
        end else if (fin_take) begin
            r_fin_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go && i_item.span_end) begin
            r_fin.well_formed <= (n_phase == dtoi_pkg::PH_DIGIT)
                              || (n_phase == dtoi_pkg::PH_TRAIL);
            r_fin.neg         <= n_neg;
            r_fin.mag         <= n_accum;
        end
    end

    assign o_fin_vld = r_fin_vld;
    assign o_fin     = r_fin;

    // A span end always leaves the parser at the start state with a clear magnitude.
    a_span_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && i_item.span_end) |=> (r_phase == dtoi_pkg::PH_LEAD && r_accum == '0
                                       && !r_neg))
        else $error("parser did not restart after span end");

    // A finished span is never overwritten before the output stage takes it.
    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fin_vld && !i_out_free) |-> !(i_go && i_item.span_end))
        else $error("finished span overwritten while stalled");

endmodule

>>> sv/dtoi_format.sv
// Output stage: range check, sign application and the result register.
module dtoi_format (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fin_vld,
    input  dtoi_pkg::t_fin      i_fin,
    input  logic                i_out_ready,
    output logic                o_out_free,
    output logic                o_out_valid,
    output dtoi_pkg::t_out_item o_out_item
);

    logic                r_out_vld;
    dtoi_pkg::t_out_item r_out;
    dtoi_pkg::t_out_item n_out;
    logic                in_range;

    assign o_out_free = !r_out_vld || i_out_ready;

    // A negative magnitude must not exceed the signed maximum.
    assign in_range = !(i_fin.neg && i_fin.mag[dtoi_pkg::NUM_W-1]);

    // Build the result; a failed or out-of-range span gives all zeros.
    always_comb begin
        n_out = '0;
        if (i_fin.well_formed && in_range) begin
            n_out.ok     = 1'b1;
            n_out.minus  = i_fin.neg;
            n_out.number = i_fin.neg ? ('0 - i_fin.mag) : i_fin.mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_out_free) begin
            r_out_vld <= i_fin_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_out_free && i_fin_vld) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // A failed result carries no sign and a zero number.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.ok) |-> (!r_out.minus && r_out.number == '0))
        else $error("failed result is not all zeros");

    // A good negative result is a negative pattern or minus zero.
    a_neg_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.ok && r_out.minus)
            |-> (r_out.number[dtoi_pkg::NUM_W-1] || r_out.number == '0))
        else $error("negative result has a positive pattern");

endmodule

>>> sv/decimal_text_to_int64.sv
// Top level of the decimal text to 64-bit integer converter.
// The block accepts one character item per clock cycle while the output side keeps
// up, and gives one result for each item that ends a span. An item passes an input
// register, the parse stage and the output register before its result is offered.
// The rate is set by the parse stage, where the magnitude update (times ten plus
// the digit with overflow check) closes its loop. Leading and trailing spaces and
// tabs are allowed, one sign is optional, and a failed span gives ok, minus and
// number all zero.
module decimal_text_to_int64 (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dtoi_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dtoi_pkg::t_out_item o_out_item
);

    logic               r_in_vld;
    dtoi_pkg::t_in_item r_in;
    logic               fin_vld;
    dtoi_pkg::t_fin     fin;
    logic               out_free;
    logic               fin_free;
    logic               s1_go;

    // Stall chain: a span end moves on if the next stage is free or being emptied.
    assign fin_free   = !fin_vld || out_free;
    assign s1_go      = r_in_vld && (!r_in.span_end || fin_free);
    assign o_in_ready = !r_in_vld || s1_go;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    dtoi_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (s1_go),
        .i_item     (r_in),
        .i_out_free (out_free),
        .o_fin_vld  (fin_vld),
        .o_fin      (fin)
    );

    dtoi_format u_format (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin_vld   (fin_vld),
        .i_fin       (fin),
        .i_out_ready (i_out_ready),
        .o_out_free  (out_free),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    // A finished span handed on shows up as a result in the next cycle.
    a_fin_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_vld && out_free) |=> o_out_valid)
        else $error("finished span did not reach the output");

    // A held input item that does not end a span never waits.
    a_no_needless_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !r_in.span_end) |-> s1_go)
        else $error("plain item stalled in the input register");

endmodule

>>> tb/sv/decimal_text_to_int64_tb.sv
// Self-checking testbench for the decimal text to 64-bit integer converter.
`timescale 1ns / 1ps

module decimal_text_to_int64_tb;

    localparam int CLK_PERIOD  = 8;
    localparam int MAX_PRINTED = 50;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    dtoi_pkg::t_in_item  i_in_item   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    dtoi_pkg::t_out_item o_out_item;

    // Mirrored parser state of the span in progress.
    dtoi_pkg::t_phase    span_phase;
    logic [63:0]         span_mag;
    logic                span_neg;

    // Conversions predicted but not yet seen at the output.
    dtoi_pkg::t_out_item expected_numbers[$];

    int unsigned items_sent     = 0;
    int unsigned mismatch_count = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;

    decimal_text_to_int64 uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #(CLK_PERIOD * 1000000);
        $display("decimal_text_to_int64 test failed");
        $finish;
    end

    function automatic bit is_blank(logic [7:0] c);
        return c == dtoi_pkg::CH_SPACE || c == dtoi_pkg::CH_TAB;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= dtoi_pkg::CH_ZERO && c <= dtoi_pkg::CH_NINE;
    endfunction

    function automatic void clear_span();
        span_phase = dtoi_pkg::PH_LEAD;
        span_mag   = '0;
        span_neg   = 1'b0;
    endfunction

    // Appends one digit to the magnitude; any carry above bit 63 fails the span.
    function automatic dtoi_pkg::t_phase push_digit(logic [7:0] c);
        logic [67:0] wide;
        wide = {4'd0, span_mag} * 68'd10 + {60'd0, c - dtoi_pkg::CH_ZERO};
        if (wide[67:64] != 4'd0) begin
            return dtoi_pkg::PH_FAIL;
        end
        span_mag = wide[63:0];
        return dtoi_pkg::PH_DIGIT;
    endfunction

    // Advances the mirrored parser by one accepted item and queues the result it ends with.
    function automatic void parse_item(dtoi_pkg::t_in_item it);
        dtoi_pkg::t_out_item res;
        logic [7:0]          c;
        c = it.char_code;
        if (it.has_char) begin
            case (span_phase)
                dtoi_pkg::PH_LEAD: begin
                    if (c == dtoi_pkg::CH_MINUS) begin
                        span_neg   = 1'b1;
                        span_phase = dtoi_pkg::PH_SIGN;
                    end else if (c == dtoi_pkg::CH_PLUS) begin
                        span_phase = dtoi_pkg::PH_SIGN;
                    end else if (is_digit(c)) begin
                        span_phase = push_digit(c);
                    end else if (!is_blank(c)) begin
                        span_phase = dtoi_pkg::PH_FAIL;
                    end
                end
                dtoi_pkg::PH_SIGN: begin
                    span_phase = is_digit(c) ? push_digit(c) : dtoi_pkg::PH_FAIL;
                end
                dtoi_pkg::PH_DIGIT: begin
                    if (is_digit(c)) begin
                        span_phase = push_digit(c);
                    end else if (is_blank(c)) begin
                        span_phase = dtoi_pkg::PH_TRAIL;
                    end else begin
                        span_phase = dtoi_pkg::PH_FAIL;
                    end
                end
                dtoi_pkg::PH_TRAIL: begin
                    if (!is_blank(c)) begin
                        span_phase = dtoi_pkg::PH_FAIL;
                    end
                end
                default: begin
                    span_phase = dtoi_pkg::PH_FAIL;
                end
            endcase
        end

        // A span ends here: a negative magnitude must not exceed the signed maximum.
        if (it.span_end) begin
            res = '0;
            if ((span_phase == dtoi_pkg::PH_DIGIT || span_phase == dtoi_pkg::PH_TRAIL) &&
                !(span_neg && span_mag[63])) begin
                res.ok     = 1'b1;
                res.minus  = span_neg;
                res.number = span_neg ? (~span_mag + 64'd1) : span_mag;
            end
            expected_numbers.push_back(res);
            clear_span();
        end
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("%0t ns: mismatch in %s: got %h, expected %h", $time, what, got, want);
        end
    endtask

    // Checks each accepted result against the oldest prediction and drives the stalls.
    always @(posedge i_clk) begin : result_check
        dtoi_pkg::t_out_item want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_numbers.size() == 0) begin
                    report_mismatch("result with none pending", o_out_item.number, '0);
                end else begin
                    want = expected_numbers.pop_front();
                    if (o_out_item.ok !== want.ok) begin
                        report_mismatch("ok", 64'(o_out_item.ok), 64'(want.ok));
                    end
                    if (o_out_item.minus !== want.minus) begin
                        report_mismatch("minus", 64'(o_out_item.minus), 64'(want.minus));
                    end
                    if (o_out_item.number !== want.number) begin
                        report_mismatch("number", o_out_item.number, want.number);
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offers one item after a random gap and waits until it is accepted.
    task automatic send_item(dtoi_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) begin
            @(posedge i_clk);
        end
        parse_item(it);
        items_sent++;
    endtask

    task automatic send_char(logic [7:0] c, logic has, logic last);
        dtoi_pkg::t_in_item it;
        it.char_code = c;
        it.has_char  = has;
        it.span_end  = last;
        send_item(it);
    endtask

    // Sends a span; it ends on its last character or on a separate empty item.
    task automatic send_span(ref logic [7:0] txt[$], input bit end_empty, input bit fillers);
        for (int i = 0; i < txt.size(); i++) begin
            if (fillers && $urandom_range(19) == 0) begin
                send_char(8'($urandom), 1'b0, 1'b0);
            end
            send_char(txt[i], 1'b1, !end_empty && i == txt.size() - 1);
        end
        if (end_empty || txt.size() == 0) begin
            send_char(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    task automatic push_text(ref logic [7:0] txt[$], input string s);
        for (int i = 0; i < s.len(); i++) begin
            txt.push_back(s[i]);
        end
    endtask

    task automatic push_decimal(ref logic [7:0] txt[$], input logic [63:0] v);
        logic [7:0] rev[$];
        do begin
            rev.push_front(dtoi_pkg::CH_ZERO + 8'(v % 10));
            v = v / 10;
        end while (v != 0);
        foreach (rev[i]) begin
            txt.push_back(rev[i]);
        end
    endtask

    task automatic send_text(string s, bit end_empty);
        logic [7:0] txt[$];
        push_text(txt, s);
        send_span(txt, end_empty, 1'b0);
    endtask

    // Holds the input side idle until every predicted result has come out.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (expected_numbers.size() != 0);
    endtask

    // Hand-picked spans: signs, blanks, empty items and malformed text.
    task automatic test_syntax_cases();
        send_text(" \t-0", 1'b1);
        send_text("+9", 1'b0);
        send_char(8'h00, 1'b0, 1'b1);
        send_text("-", 1'b0);
        send_text("- 5", 1'b0);
        send_text("+-1", 1'b0);
        send_char(8'hFF, 1'b1, 1'b1);
        send_char(8'h00, 1'b1, 1'b1);
        // An empty item inside the trailing blanks must leave the span intact.
        send_char(dtoi_pkg::CH_ZERO + 8'd4, 1'b1, 1'b0);
        send_char(dtoi_pkg::CH_SPACE, 1'b1, 1'b0);
        send_char(8'hFF, 1'b0, 1'b0);
        send_char(dtoi_pkg::CH_TAB, 1'b1, 1'b1);
        send_text("1 2", 1'b0);
        wait_for_results();
    endtask

    // Mostly well-formed numbers, many near the range limits, some broken, some pure noise.
    task automatic test_random_spans(int unsigned send_pct, int unsigned recv_pct,
                                     int unsigned n_items);
        logic [7:0]  txt[$];
        int unsigned stop_at;
        int unsigned pick;
        stop_at       = items_sent + n_items;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            txt.delete();
            if (pick < 15) begin
                repeat ($urandom_range(3)) begin
                    send_char(8'($urandom), 1'($urandom), 1'b0);
                end
                send_char(8'($urandom), 1'($urandom), 1'b1);
            end else begin
                // Leading blanks and an optional sign.
                repeat ($urandom_range(2)) begin
                    txt.push_back($urandom_range(1) ? dtoi_pkg::CH_SPACE : dtoi_pkg::CH_TAB);
                end
                case ($urandom_range(2))
                    1: txt.push_back(dtoi_pkg::CH_PLUS);
                    2: txt.push_back(dtoi_pkg::CH_MINUS);
                    default: ;
                endcase

                // Digits: small, full width, unsigned/signed limits, zero-led, or too long.
                case ($urandom_range(5))
                    0: push_decimal(txt, 64'($urandom_range(999)));
                    1: push_decimal(txt, {$urandom, $urandom});
                    2: begin
                        push_text(txt, "1844674407370955161");
                        txt.push_back(dtoi_pkg::CH_ZERO + 8'($urandom_range(9)));
                    end
                    3: begin
                        push_text(txt, "922337203685477580");
                        txt.push_back(dtoi_pkg::CH_ZERO + 8'($urandom_range(9)));
                    end
                    4: begin
                        repeat ($urandom_range(3, 1)) begin
                            txt.push_back(dtoi_pkg::CH_ZERO);
                        end
                        push_decimal(txt, 64'($urandom_range(99999)));
                    end
                    default: begin
                        txt.push_back(dtoi_pkg::CH_ZERO + 8'($urandom_range(9, 1)));
                        repeat ($urandom_range(22, 19)) begin
                            txt.push_back(dtoi_pkg::CH_ZERO + 8'($urandom_range(9)));
                        end
                    end
                endcase

                repeat ($urandom_range(2)) begin
                    txt.push_back($urandom_range(1) ? dtoi_pkg::CH_SPACE : dtoi_pkg::CH_TAB);
                end

                // Break some spans with a stray byte or a misplaced blank or sign.
                if (pick < 30) begin
                    if ($urandom_range(1)) begin
                        txt.insert($urandom_range(txt.size()), 8'($urandom));
                    end else begin
                        txt[$urandom_range(txt.size() - 1)] =
                            $urandom_range(1) ? dtoi_pkg::CH_SPACE : dtoi_pkg::CH_MINUS;
                    end
                end
                send_span(txt, $urandom_range(3) == 0, 1'b1);
            end
        end
        wait_for_results();
    endtask

    initial begin
        clear_span();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 17;
        recv_idle_pct = 62;
        test_syntax_cases();
        test_random_spans(17, 62, 620);
        test_random_spans(62, 17, 620);
        test_random_spans(0, 0, 620);

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_numbers.size() == 0) begin
            $display("decimal_text_to_int64 test passed");
        end else begin
            $display("decimal_text_to_int64 test failed");
        end
        $finish;
    end

endmodule
